// ===== rtl/pixel_alpha_compositor_defines.svh =====
// ----------------------------------------------------------------------------
// pixel_alpha_compositor_defines
// assertion macros used by the compositor top level
// ----------------------------------------------------------------------------
`ifndef PIXEL_ALPHA_COMPOSITOR_DEFINES_SVH
`define PIXEL_ALPHA_COMPOSITOR_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define PAC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define PAC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/pac_pkg.sv =====
// ----------------------------------------------------------------------------
// pac_pkg
// types and codes shared by the alpha compositor modules
// ----------------------------------------------------------------------------
package pac_pkg;

	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 8;

	localparam logic [CFG_INDEX_W-1:0] REG_OPACITY     = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_MODE = 4'd1;

	localparam logic [1:0] MODE_RGBA    = 2'd0;
	localparam logic [1:0] MODE_RGB     = 2'd1;
	localparam logic [1:0] MODE_PALETTE = 2'd2;

	localparam logic ACT_BLEND = 1'b0;
	localparam logic ACT_LOAD  = 1'b1;

	localparam logic [7:0] WEIGHT_FULL = 8'd255;
	localparam logic [7:0] WEIGHT_NONE = 8'd0;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	// load enables of the pipeline stages
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} pipe_en_t;

	typedef enum logic [1:0] {
		SEL_MIX,
		SEL_TOP,
		SEL_BOTTOM
	} blend_sel_t;

endpackage

// ===== rtl/pac_palette.sv =====
// ----------------------------------------------------------------------------
// pac_palette
// colour table, one write port and one registered read port
// ----------------------------------------------------------------------------
module pac_palette #(
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  pac_pkg::rgb_t            wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output pac_pkg::rgb_t            rd_s1
);

	pac_pkg::rgb_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_s1 <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/pac_weight.sv =====
// ----------------------------------------------------------------------------
// pac_weight
// blend weight: alpha times opacity over 255, or opacity, or zero, by source mode
// ----------------------------------------------------------------------------
module pac_weight (
	input  logic              clk,
	input  pac_pkg::pipe_en_t en,
	input  logic [7:0]        alpha_s1,
	input  logic [7:0]        opacity_s1,
	input  logic [1:0]        mode_s1,
	output logic [7:0]        w_s3
);

	logic [15:0] prod_s2;
	logic [7:0]  opacity_s2;
	logic [1:0]  mode_s2;
	logic [15:0] rounded;
	logic [16:0] quot;
	logic [7:0]  w_next;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			prod_s2    <= 16'(alpha_s1) * 16'(opacity_s1);
			opacity_s2 <= opacity_s1;
			mode_s2    <= mode_s1;
		end
	end

	// x / 255 as (x + 1 + x / 256) / 256, exact below 65535
	always_comb begin
		rounded = prod_s2 + 16'd127;
		quot    = 17'(rounded) + 17'd1 + 17'(rounded[15:8]);
		case (mode_s2)
			pac_pkg::MODE_RGBA:    w_next = quot[15:8];
			pac_pkg::MODE_RGB:     w_next = opacity_s2;
			pac_pkg::MODE_PALETTE: w_next = opacity_s2;
			default:               w_next = pac_pkg::WEIGHT_NONE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			w_s3 <= w_next;
		end
	end

endmodule

// ===== rtl/pac_blend_lane.sv =====
// ----------------------------------------------------------------------------
// pac_blend_lane
// one colour channel: t at w 255, b at w 0, else b + ((t - b) * w + 127) / 255, truncated toward zero
// ----------------------------------------------------------------------------
module pac_blend_lane (
	input  logic              clk,
	input  pac_pkg::pipe_en_t en,
	input  logic [7:0]        t_s3,
	input  logic [7:0]        b_s3,
	input  logic [7:0]        w_s3,
	output logic [7:0]        out_s5
);

	logic signed [17:0]  mix_s4;
	logic [7:0]          t_s4;
	logic [7:0]          b_s4;
	pac_pkg::blend_sel_t sel_s4;

	logic signed [8:0]   diff;
	logic signed [17:0]  diff_x;
	logic signed [17:0]  w_x;
	logic signed [17:0]  mix_next;
	pac_pkg::blend_sel_t sel_next;
	logic                neg;
	logic [17:0]         mag_full;
	logic [16:0]         quot;
	logic [7:0]          q_mag;
	logic [7:0]          q;
	logic [7:0]          out_next;

	always_comb begin
		diff     = signed'({1'b0, t_s3}) - signed'({1'b0, b_s3});
		diff_x   = 18'(diff);
		w_x      = signed'(18'({1'b0, w_s3}));
		mix_next = diff_x * w_x + 18'sd127;
		if (w_s3 == pac_pkg::WEIGHT_FULL) begin
			sel_next = pac_pkg::SEL_TOP;
		end else if (w_s3 == pac_pkg::WEIGHT_NONE) begin
			sel_next = pac_pkg::SEL_BOTTOM;
		end else begin
			sel_next = pac_pkg::SEL_MIX;
		end
	end

	always_ff @(posedge clk) begin
		if (en.s4) begin
			mix_s4 <= mix_next;
			t_s4   <= t_s3;
			b_s4   <= b_s3;
			sel_s4 <= sel_next;
		end
	end

	// magnitude over 255, sign put back afterwards
	always_comb begin
		neg      = mix_s4[17];
		mag_full = neg ? 18'(-mix_s4) : 18'(mix_s4);
		quot     = mag_full[16:0] + 17'd1 + 17'(mag_full[16:8]);
		q_mag    = quot[15:8];
		q        = neg ? (8'd0 - q_mag) : q_mag;
		case (sel_s4)
			pac_pkg::SEL_TOP:    out_next = t_s4;
			pac_pkg::SEL_BOTTOM: out_next = b_s4;
			default:             out_next = b_s4 + q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en.s5) begin
			out_s5 <= out_next;
		end
	end

endmodule

// ===== rtl/pixel_alpha_compositor.sv =====
// a blend beat taken at the input passes stage registers s1 to s5 and is offered on the output from s5
// throughput: one beat per cycle, blend or palette load, while out_stall does not hold the five-stage pipeline
// palette loads write the table through its write port and give no output beat
// reset: asynchronous, active low; clears valid bits, opacity to 255, mode to 0
// the colour table is not cleared and holds undefined data until loaded
// ----------------------------------------------------------------------------
// pixel_alpha_compositor
// rgb888 alpha blender with global opacity and palette source
// ----------------------------------------------------------------------------
`include "pixel_alpha_compositor_defines.svh"

module pixel_alpha_compositor #(
	parameter int PALETTE_DEPTH = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,

	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pac_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [pac_pkg::CFG_DATA_W-1:0]  cfg_data,

	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            action,
	input  logic [7:0]                      top_red,
	input  logic [7:0]                      top_green,
	input  logic [7:0]                      top_blue,
	input  logic [7:0]                      top_alpha,
	input  logic [7:0]                      top_index,
	input  logic [7:0]                      bottom_red,
	input  logic [7:0]                      bottom_green,
	input  logic [7:0]                      bottom_blue,

	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [7:0]                      out_red,
	output logic [7:0]                      out_green,
	output logic [7:0]                      out_blue
);

	localparam int AW = $clog2(PALETTE_DEPTH);

	logic [7:0] opacity_q;
	logic [1:0] mode_q;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	pac_pkg::pipe_en_t en;

	logic          accept;
	logic          idx_ok;
	pac_pkg::rgb_t top_in;
	pac_pkg::rgb_t rd_s1;

	pac_pkg::rgb_t t_s1, b_s1;
	logic [7:0]    alpha_s1, opacity_s1;
	logic [1:0]    mode_s1;
	logic          idx_ok_s1;
	pac_pkg::rgb_t t_s2, b_s2, t_s3, b_s3;
	logic [7:0]    w_s3;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			opacity_q <= 8'd255;
			mode_q    <= pac_pkg::MODE_RGBA;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pac_pkg::REG_OPACITY:     opacity_q <= cfg_data;
				pac_pkg::REG_SOURCE_MODE: mode_q    <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// a stage loads when it is empty or the next one moves on
	always_comb begin
		en.s5 = !valid_s5 || !out_stall;
		en.s4 = !valid_s4 || en.s5;
		en.s3 = !valid_s3 || en.s4;
		en.s2 = !valid_s2 || en.s3;
		en.s1 = !valid_s1 || en.s2;
	end

	assign in_stall  = !en.s1;
	assign accept    = in_valid && en.s1;
	assign out_valid = valid_s5;
	assign idx_ok    = {1'b0, top_index} < 9'(PALETTE_DEPTH);
	assign top_in    = '{red: top_red, green: top_green, blue: top_blue};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en.s1) valid_s1 <= in_valid && (action == pac_pkg::ACT_BLEND);
			if (en.s2) valid_s2 <= valid_s1;
			if (en.s3) valid_s3 <= valid_s2;
			if (en.s4) valid_s4 <= valid_s3;
			if (en.s5) valid_s5 <= valid_s4;
		end
	end

	pac_palette #(
		.DEPTH(PALETTE_DEPTH)
	) u_palette (
		.clk    (clk),
		.wr_en  (accept && (action == pac_pkg::ACT_LOAD) && idx_ok),
		.wr_addr(top_index[AW-1:0]),
		.wr_data(top_in),
		.rd_en  (accept && (action == pac_pkg::ACT_BLEND)),
		.rd_addr(top_index[AW-1:0]),
		.rd_s1  (rd_s1)
	);

	always_ff @(posedge clk) begin
		if (en.s1) begin
			t_s1       <= top_in;
			b_s1       <= '{red: bottom_red, green: bottom_green, blue: bottom_blue};
			alpha_s1   <= top_alpha;
			opacity_s1 <= opacity_q;
			mode_s1    <= mode_q;
			idx_ok_s1  <= idx_ok;
		end
		if (en.s2) begin
			if (mode_s1 == pac_pkg::MODE_PALETTE) begin
				t_s2 <= idx_ok_s1 ? rd_s1 : '0;
			end else begin
				t_s2 <= t_s1;
			end
			b_s2 <= b_s1;
		end
		if (en.s3) begin
			t_s3 <= t_s2;
			b_s3 <= b_s2;
		end
	end

	pac_weight u_weight (
		.clk       (clk),
		.en        (en),
		.alpha_s1  (alpha_s1),
		.opacity_s1(opacity_s1),
		.mode_s1   (mode_s1),
		.w_s3      (w_s3)
	);

	pac_blend_lane u_lane_red (
		.clk   (clk),
		.en    (en),
		.t_s3  (t_s3.red),
		.b_s3  (b_s3.red),
		.w_s3  (w_s3),
		.out_s5(out_red)
	);

	pac_blend_lane u_lane_green (
		.clk   (clk),
		.en    (en),
		.t_s3  (t_s3.green),
		.b_s3  (b_s3.green),
		.w_s3  (w_s3),
		.out_s5(out_green)
	);

	pac_blend_lane u_lane_blue (
		.clk   (clk),
		.en    (en),
		.t_s3  (t_s3.blue),
		.b_s3  (b_s3.blue),
		.w_s3  (w_s3),
		.out_s5(out_blue)
	);

	`PAC_ASSERT_NEXT(a_load_no_beat, accept && (action == pac_pkg::ACT_LOAD), !valid_s1, "load beat entered the pipeline")
	`PAC_ASSERT_NEXT(a_s2_hold, valid_s2 && !en.s3, valid_s2, "stalled stage two lost its beat")
	`PAC_ASSERT_NOW(a_stall_full, in_stall, valid_s1, "input stalled with stage one empty")
	`PAC_ASSERT_NOW(a_free_flow, !out_stall, !in_stall, "input stalled while output drains")

endmodule
